>>> sv/assert_macros.svh
// Assertion macros used by the controller of the hash unit.
// Defining NO_ASSERTIONS turns every macro into an empty body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst, lhs, rhs)
`endif
`endif

>>> sv/lpfnv_pkg.sv
// Package for the length-prefixed FNV-1a hash unit: constants, the byte fold
// function and the command and status structs. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package lpfnv_pkg;
   localparam int HASH_W = 64;
   localparam int LEN_W = 64;
   localparam int BYTE_W = 8;
   localparam int LEN_FOLDS = LEN_W / BYTE_W;
   localparam int FOLD_CNT_W = $clog2(LEN_FOLDS);
   localparam logic [FOLD_CNT_W-1:0] LAST_FOLD = FOLD_CNT_W'(LEN_FOLDS - 1);
   localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hcbf29ce484222325;
   localparam logic REQ_START = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic start;
      logic fold_len;
      logic len_done;
      logic fold_data;
      logic capture;
   } ctrl_cmd_type;

   typedef struct packed {
      logic open;
      logic last_byte;
      logic len_zero;
   } dp_status_type;

   // The FNV prime is 2^40 + 0x1b3, so the product is a sum of shifted copies.
   function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                  input logic [BYTE_W-1:0] b);
      logic [HASH_W-1:0] x;
      x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
      return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
   endfunction
endpackage
`default_nettype wire

>>> sv/lpfnv_dp.sv
// Datapath of the hash unit: running hash, byte counter, length shifter and
// the result register. It depends on lpfnv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpfnv_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lpfnv_pkg::ctrl_cmd_type      cmd,
   input  wire logic [lpfnv_pkg::LEN_W-1:0]  total_length,
   input  wire logic [lpfnv_pkg::BYTE_W-1:0] data_byte,
   output lpfnv_pkg::dp_status_type          status,
   output logic [lpfnv_pkg::HASH_W-1:0]      hash_value
);
   import lpfnv_pkg::*;

   logic [HASH_W-1:0] hash_ff, hash_in, hash_fold, out_ff, out_in;
   logic [LEN_W-1:0]  remaining_ff, remaining_in, len_sh_ff, len_sh_in;
   logic              open_ff, open_in;
   logic [BYTE_W-1:0] fold_src;

   assign fold_src = cmd.fold_len ? len_sh_ff[BYTE_W-1:0] : data_byte;
   assign hash_fold = fnv_fold(hash_ff, fold_src);

   always_comb begin
      hash_in = hash_ff;
      remaining_in = remaining_ff;
      len_sh_in = len_sh_ff;
      open_in = open_ff;
      out_in = out_ff;
      if (cmd.start) begin
         hash_in = FNV_OFFSET_BASIS;
         remaining_in = total_length;
         len_sh_in = total_length;
         open_in = 1'b0;
      end else if (cmd.fold_len) begin
         hash_in = hash_fold;
         len_sh_in = len_sh_ff >> BYTE_W;
         if (cmd.len_done) begin
            open_in = (remaining_ff != '0);
         end
      end else if (cmd.fold_data) begin
         hash_in = hash_fold;
         remaining_in = remaining_ff - LEN_W'(1);
         if (status.last_byte) begin
            open_in = 1'b0;
         end
      end
      if (cmd.capture) begin
         out_in = hash_fold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff <= FNV_OFFSET_BASIS;
         remaining_ff <= '0;
         open_ff <= 1'b0;
      end else begin
         hash_ff <= hash_in;
         remaining_ff <= remaining_in;
         open_ff <= open_in;
      end
      len_sh_ff <= len_sh_in;
      out_ff <= out_in;
   end

   assign status.open = open_ff;
   assign status.last_byte = (remaining_ff == LEN_W'(1));
   assign status.len_zero = (remaining_ff == '0);
   assign hash_value = out_ff;
endmodule
`default_nettype wire

>>> sv/lpfnv_ctrl.sv
// Controller of the hash unit: handshakes, the length fold sequencer and the
// result valid flag. It depends on lpfnv_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module lpfnv_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic                      req_type,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire lpfnv_pkg::dp_status_type  status,
   output lpfnv_pkg::ctrl_cmd_type        cmd
);
   import lpfnv_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FOLD = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [FOLD_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept = req_valid && req_ready;

   always_comb begin
      cmd.start = accept && (req_type == REQ_START);
      cmd.fold_data = accept && (req_type == REQ_DATA) && status.open;
      cmd.fold_len = (state_ff == ST_FOLD);
      cmd.len_done = cmd.fold_len && (cnt_ff == LAST_FOLD);
      cmd.capture = (cmd.len_done && status.len_zero) ||
                    (cmd.fold_data && status.last_byte);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_FOLD;
               cnt_in = '0;
            end
         end
         ST_FOLD: begin
            cnt_in = cnt_ff + FOLD_CNT_W'(1);
            if (cmd.len_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_IMPLIES(a_no_accept_in_fold, clock, reset, state_ff == ST_FOLD, !req_ready)
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.capture, !rsp_valid_ff || rsp_ready)
   `ASSERT_NEXT(a_start_folds, clock, reset, cmd.start, state_ff == ST_FOLD && cnt_ff == '0)
   `ASSERT_NEXT(a_fold_ends, clock, reset, cmd.len_done, state_ff == ST_IDLE)
endmodule
`default_nettype wire

>>> sv/length_prefixed_fnv1a_hash_unit.sv
// Length-prefixed 64-bit FNV-1a hash unit: top level joining controller and datapath.
// A new data item is taken each cycle while req_ready is high (no length fold, no
// held-back result); the last byte's hash is in the result register in the cycle after
// acceptance. After a start, eight length-byte folds run through the single fold unit.
// Synchronous active-high reset sets the hash to the offset basis and closes the message.
`timescale 1ns / 1ps
`default_nettype none
module length_prefixed_fnv1a_hash_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_type,
   input  wire logic [lpfnv_pkg::LEN_W-1:0]  req_total_length,
   input  wire logic [lpfnv_pkg::BYTE_W-1:0] req_data_byte,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [lpfnv_pkg::HASH_W-1:0]      rsp_hash_value
);
   import lpfnv_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   lpfnv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lpfnv_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .total_length (req_total_length),
      .data_byte    (req_data_byte),
      .status       (status),
      .hash_value   (rsp_hash_value)
   );
endmodule
`default_nettype wire

>>> sim/length_prefixed_fnv1a_hash_unit_test.sv
// Self-checking testbench for the length-prefixed FNV-1a hash unit: a directed table,
// then random messages, with a local hash predictor and random idling on both channels.
// Depends on lpfnv_pkg and length_prefixed_fnv1a_hash_unit.
`timescale 1ns / 1ps
module length_prefixed_fnv1a_hash_unit_test;
   localparam logic [63:0] FNV_PRIME_64 = 64'd1099511628211;
   localparam int LIMIT_CYCLES = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_ITEMS = 1550;
   localparam int DRAIN_CYCLES = 24;
   localparam int DIRECTED_ROWS = 24;

   typedef struct packed {
      logic        kind;
      logic [63:0] length;
      logic [7:0]  data;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [63:0] req_total_length;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_hash_value;

   logic [63:0] model_hash;
   logic [63:0] model_left;
   logic        model_open;
   logic [63:0] expected_hashes[$];

   int idle_phase = 0;
   int prev_phase = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int hashes_checked = 0;
   int folded_items = 0;
   int accepted_items = 0;
   int messages_cut = 0;

   stim_row_type directed_rows [0:DIRECTED_ROWS-1] = '{
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'hff},
      '{lpfnv_pkg::REQ_START, 64'h0,                 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h00},
      '{lpfnv_pkg::REQ_START, 64'h1,                 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h00},
      '{lpfnv_pkg::REQ_START, 64'h1,                 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'hffff_ffff_ffff_ffff, 8'hff},
      '{lpfnv_pkg::REQ_START, 64'h3,                 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'ha5},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h5a},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'hff},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h3c},
      '{lpfnv_pkg::REQ_START, 64'hffff_ffff_ffff_ffff, 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h01},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h80},
      '{lpfnv_pkg::REQ_START, 64'h2,                 8'hff},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h12},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h34},
      '{lpfnv_pkg::REQ_START, 64'h8000_0000_0000_0000, 8'h00},
      '{lpfnv_pkg::REQ_START, 64'h0,                 8'h00},
      '{lpfnv_pkg::REQ_START, 64'h0000_0001_0000_0000, 8'h00},
      '{lpfnv_pkg::REQ_START, 64'h1,                 8'h00},
      '{lpfnv_pkg::REQ_DATA,  64'h0,                 8'h7e},
      '{lpfnv_pkg::REQ_START, 64'h0,                 8'h00}
   };

   length_prefixed_fnv1a_hash_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_total_length (req_total_length),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_hash_value   (rsp_hash_value)
   );

   always #1 clock = ~clock;

   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME_64;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int tx_idle_pct();
      case (idle_phase)
         0: return 11;
         1: return 51;
         default: return 0;
      endcase
   endfunction

   function automatic int rx_idle_pct();
      case (idle_phase)
         0: return 51;
         1: return 11;
         default: return 0;
      endcase
   endfunction

   task automatic track_item(input logic kind, input logic [63:0] len, input logic [7:0] b);
      logic [63:0] h;
      accepted_items++;
      if (kind == lpfnv_pkg::REQ_START) begin
         if (model_open) messages_cut++;
         h = lpfnv_pkg::FNV_OFFSET_BASIS;
         for (int s = 0; s < 8; s++) h = fnv_mix(h, len[8*s +: 8]);
         model_hash = h;
         model_left = len;
         model_open = (len != 64'd0);
         folded_items++;
         if (len == 64'd0) expected_hashes.push_back(model_hash);
      end else if (model_open && model_left != 64'd0) begin
         model_hash = fnv_mix(model_hash, b);
         model_left = model_left - 64'd1;
         folded_items++;
         if (model_left == 64'd0) begin
            model_open = 1'b0;
            expected_hashes.push_back(model_hash);
         end
      end
   endtask

   task automatic send_item(input logic kind, input logic [63:0] len, input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_total_length <= len;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      track_item(kind, len, b);
   endtask

   task automatic random_message();
      int shape;
      int pick;
      int cut;
      logic [63:0] len;
      shape = $urandom_range(99);
      if (shape < 70) begin
         pick = $urandom_range(99);
         if (pick < 6) len = 64'd0;
         else if (pick < 12) len = 64'($urandom_range(300, 17));
         else len = 64'($urandom_range(16, 1));
         send_item(lpfnv_pkg::REQ_START, len, 8'($urandom));
         for (longint i = 0; i < longint'(len); i++)
            send_item(lpfnv_pkg::REQ_DATA, rand64(), 8'($urandom));
         if ($urandom_range(9) == 0)
            send_item(lpfnv_pkg::REQ_DATA, rand64(), 8'($urandom));
      end else if (shape < 85) begin
         len = ($urandom_range(1) == 0) ? rand64() : 64'($urandom_range(40, 2));
         if (len < 64'd2) len = 64'd2;
         cut = (len > 64'd13) ? $urandom_range(12) : $urandom_range(int'(len) - 1);
         send_item(lpfnv_pkg::REQ_START, len, 8'($urandom));
         for (int i = 0; i < cut; i++)
            send_item(lpfnv_pkg::REQ_DATA, rand64(), 8'($urandom));
      end else begin
         cut = $urandom_range(3, 1);
         for (int i = 0; i < cut; i++)
            send_item(lpfnv_pkg::REQ_DATA, rand64(), 8'($urandom));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hashes.size() == 0) begin
            $display("%0t unexpected result: expected none, actual hash_value %h",
                     $time, rsp_hash_value);
            mismatch_count++;
         end else begin
            if (rsp_hash_value !== expected_hashes[0]) begin
               $display("%0t hash_value mismatch: expected %h, actual %h",
                        $time, expected_hashes[0], rsp_hash_value);
               mismatch_count++;
            end
            void'(expected_hashes.pop_front());
            hashes_checked++;
         end
      end
      prev_phase <= idle_phase;
      if (idle_phase == 1 && prev_phase == 0) begin
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct());
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("%0t timeout after %0d cycles, %0d results outstanding",
                  $time, cycle_count, expected_hashes.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int random_base;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = lpfnv_pkg::REQ_START;
      req_total_length = 64'd0;
      req_data_byte = 8'd0;
      rsp_ready = 1'b0;
      model_hash = lpfnv_pkg::FNV_OFFSET_BASIS;
      model_left = 64'd0;
      model_open = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].kind, directed_rows[i].length, directed_rows[i].data);

      random_base = folded_items;
      while (folded_items < random_base + RANDOM_ITEMS) begin
         if (folded_items >= random_base + 2 * RANDOM_ITEMS / 3) idle_phase <= 2;
         else if (folded_items >= random_base + RANDOM_ITEMS / 3) idle_phase <= 1;
         random_message();
      end
      req_valid <= 1'b0;

      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d items (%0d folded), %0d hashes checked, %0d messages cut short",
               accepted_items, folded_items, hashes_checked, messages_cut);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
